FILE: src/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg: shared types and constants for the random permutation draw
// Holds field widths, register indexes, reset values and the sequencer types.
// ----------------------------------------------------------------------------
package rpd_pkg;

  // field widths
  localparam int WORD_W  = 32;
  localparam int CFG_W   = 11;
  localparam int PERM_W  = 10;
  localparam int CFG_IDX_W = 1;

  // default pool capacity
  localparam int DEFAULT_MAX_SIZE = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERM_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] RESET_PERM_SIZE  = 11'd1024;
  localparam logic [CFG_W-1:0] RESET_PICK_COUNT = 11'd1024;

  // sequencer states: idle, remainder running, pool closing the gap
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SHIFT
  } state_t;

  // pool commands from the sequencer
  typedef struct packed {
    logic refill;
    logic draw;
  } pool_cmd_t;

endpackage

FILE: src/rpd_mod_unit.sv
// ----------------------------------------------------------------------------
// rpd_mod_unit: iterative remainder unit
// Restoring division of a 32-bit word by an 11-bit count, one bit per cycle;
// only the remainder is kept.
// ----------------------------------------------------------------------------
module rpd_mod_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rpd_pkg::WORD_W-1:0]    dividend,
  input  logic [rpd_pkg::CFG_W-1:0]     divisor,
  output logic                          done,
  output logic [rpd_pkg::CFG_W-1:0]     rem
);

  localparam int CNT_W = $clog2(rpd_pkg::WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rpd_pkg::WORD_W - 1);

  logic                        active_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [rpd_pkg::WORD_W-1:0]  quo_r;
  logic [rpd_pkg::CFG_W-1:0]   div_r;
  logic [rpd_pkg::CFG_W-1:0]   rem_r;
  logic [rpd_pkg::CFG_W:0]     trial;
  logic [rpd_pkg::CFG_W-1:0]   rem_nxt;

  // one trial subtract per cycle
  always_comb begin
    trial = {rem_r, quo_r[rpd_pkg::WORD_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = rpd_pkg::CFG_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[rpd_pkg::CFG_W-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (active_r) begin
      quo_r <= {quo_r[rpd_pkg::WORD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: src/rpd_pool.sv
// ----------------------------------------------------------------------------
// rpd_pool: memory pool of remaining values
// Reads the entry at the drawn position, then closes the gap by moving the
// entries above it down one per cycle. Entries below a low-water mark read as
// their own position, so a refill only has to reset the mark.
// ----------------------------------------------------------------------------
module rpd_pool #(
  parameter int MAX_SIZE = rpd_pkg::DEFAULT_MAX_SIZE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rpd_pkg::pool_cmd_t            cmd,
  input  logic [$clog2(MAX_SIZE)-1:0]   pos,
  input  logic [$clog2(MAX_SIZE):0]     count,
  output logic [rpd_pkg::PERM_W-1:0]    rd_data,
  output logic                          done
);

  localparam int IDX_W = $clog2(MAX_SIZE);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] LOW_EMPTY = CNT_W'(MAX_SIZE);

  logic [rpd_pkg::PERM_W-1:0] mem_r [MAX_SIZE];
  logic [rpd_pkg::PERM_W-1:0] mem_q_r;
  logic [rpd_pkg::PERM_W-1:0] rd_data_r;
  logic                       active_r;
  logic                       done_r;
  logic [CNT_W-1:0]           low_r;
  logic [CNT_W-1:0]           pos_r;
  logic [CNT_W-1:0]           end_r;
  logic [CNT_W-1:0]           rd_idx_r;
  logic                       stg_take_r;
  logic                       stg_ident_r;
  logic [CNT_W-1:0]           stg_idx_r;

  logic                       issue;
  logic                       finish;
  logic                       take;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [rpd_pkg::PERM_W-1:0] stg_data;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;

  // read one entry ahead, write the entry read last cycle one place down
  always_comb begin
    issue    = active_r && (rd_idx_r < end_r);
    finish   = active_r && !issue;
    take     = active_r && stg_take_r;
    rd_en    = cmd.draw || issue;
    rd_addr  = cmd.draw ? pos : IDX_W'(rd_idx_r);
    stg_data = stg_ident_r ? rpd_pkg::PERM_W'(stg_idx_r) : mem_q_r;
    wr_en    = active_r && !stg_take_r;
    wr_addr  = IDX_W'(stg_idx_r - 1'b1);
  end

  // pool memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= stg_data;
    end
    if (rd_en) begin
      mem_q_r <= mem_r[rd_addr];
    end
  end

  // shift control and low-water mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      low_r    <= LOW_EMPTY;
    end else begin
      done_r <= finish;
      if (cmd.draw) begin
        active_r <= 1'b1;
      end else if (finish) begin
        active_r <= 1'b0;
      end
      if (cmd.refill) begin
        low_r <= LOW_EMPTY;
      end else if (finish && (pos_r < low_r)) begin
        low_r <= pos_r;
      end
    end
  end

  // walk pointers and drawn word
  always_ff @(posedge clk) begin
    if (cmd.draw) begin
      pos_r       <= {1'b0, pos};
      end_r       <= count;
      rd_idx_r    <= {1'b0, pos} + 1'b1;
      stg_take_r  <= 1'b1;
      stg_idx_r   <= {1'b0, pos};
      stg_ident_r <= ({1'b0, pos} < low_r);
    end else if (issue) begin
      rd_idx_r    <= rd_idx_r + 1'b1;
      stg_take_r  <= 1'b0;
      stg_idx_r   <= rd_idx_r;
      stg_ident_r <= (rd_idx_r < low_r);
    end
    if (take) begin
      rd_data_r <= stg_data;
    end
  end

  assign rd_data = rd_data_r;
  assign done    = done_r;

endmodule

FILE: src/rpd_ctrl.sv
// ----------------------------------------------------------------------------
// rpd_ctrl: draw sequencer and configuration registers
// Holds size, pick count and the draw counter, starts the remainder unit and
// issues the pool draw and refill commands.
// ----------------------------------------------------------------------------
module rpd_ctrl #(
  parameter int MAX_SIZE = rpd_pkg::DEFAULT_MAX_SIZE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rpd_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                            div_start,
  output logic [rpd_pkg::CFG_W-1:0]       div_divisor,
  input  logic                            div_done,
  output rpd_pkg::pool_cmd_t              pool_cmd,
  input  logic                            pool_done,
  output logic                            out_valid,
  output logic                            out_last
);

  rpd_pkg::state_t state_r, state_nxt;

  logic [rpd_pkg::CFG_W-1:0] perm_size_r;
  logic [rpd_pkg::CFG_W-1:0] pick_count_r;
  logic [rpd_pkg::CFG_W-1:0] drawn_r, drawn_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_last_r, out_last_nxt;

  logic [rpd_pkg::CFG_W-1:0] size_raw;
  logic [rpd_pkg::CFG_W-1:0] eff_size;
  logic [rpd_pkg::CFG_W-1:0] pick_raw;
  logic [rpd_pkg::CFG_W-1:0] eff_pick;
  logic [rpd_pkg::CFG_W-1:0] drawn_inc;
  logic                      is_last;
  logic                      draw_go;
  logic                      finish;

  // effective size and pick count
  always_comb begin
    size_raw = (perm_size_r == '0) ? rpd_pkg::CFG_W'(1) : perm_size_r;
    if (32'(size_raw) > MAX_SIZE) begin
      eff_size = rpd_pkg::CFG_W'(MAX_SIZE);
    end else begin
      eff_size = size_raw;
    end
    pick_raw = (pick_count_r == '0) ? rpd_pkg::CFG_W'(1) : pick_count_r;
    eff_pick = (pick_raw > eff_size) ? eff_size : pick_raw;
  end

  assign drawn_inc = drawn_r + 1'b1;
  assign is_last   = (drawn_inc >= eff_pick);
  assign draw_go   = (state_r == rpd_pkg::ST_DRAW) && div_done;
  assign finish    = (state_r == rpd_pkg::ST_SHIFT) && pool_done;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpd_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = rpd_pkg::ST_DRAW;
        end
      end
      rpd_pkg::ST_DRAW: begin
        if (div_done) begin
          state_nxt = rpd_pkg::ST_SHIFT;
        end
      end
      rpd_pkg::ST_SHIFT: begin
        if (pool_done) begin
          state_nxt = rpd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rpd_pkg::ST_IDLE;
    endcase
  end

  // outputs and counter updates
  always_comb begin
    busy          = (state_r != rpd_pkg::ST_IDLE);
    div_start     = (state_r == rpd_pkg::ST_IDLE) && start;
    div_divisor   = eff_size - drawn_r;
    pool_cmd.draw   = draw_go;
    pool_cmd.refill = cfg_we || (finish && is_last);
    out_valid_nxt = finish;
    out_last_nxt  = finish && is_last;
    drawn_nxt     = drawn_r;
    if (cfg_we) begin
      drawn_nxt = '0;
    end else if (finish) begin
      drawn_nxt = is_last ? '0 : drawn_inc;
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rpd_pkg::ST_IDLE;
      perm_size_r  <= rpd_pkg::RESET_PERM_SIZE;
      pick_count_r <= rpd_pkg::RESET_PICK_COUNT;
      drawn_r      <= '0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drawn_r     <= drawn_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          rpd_pkg::REG_PERM_SIZE:  perm_size_r  <= cfg_wdata;
          rpd_pkg::REG_PICK_COUNT: pick_count_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;

endmodule

FILE: src/random_permutation_draw.sv
// ----------------------------------------------------------------------------
// random_permutation_draw: draws a permutation prefix without replacement
// Each word brings a 32-bit random value; the block emits one pool value per
// word and removes it from the pool.
// ----------------------------------------------------------------------------
// Usage:
//   Input: pulse start with in_random_word while busy is low; the word is
//   taken at that edge and busy stays high until the draw is done.
//   Output: out_valid strobes for one cycle with out_perm_value and
//   out_last_of_run; the receiver cannot stall, so it must take the word then.
//   Sequence: with r entries left and the drawn one at position p, the
//   remainder unit works through the word, one quotient bit per cycle, and
//   hands the position to the pool, which reads the drawn entry and then
//   moves the r-p-1 entries above it down, one per cycle. The result is on
//   the ports as busy falls, so the next word waits for the draw to end.
//   Configuration: cfg_we writes register cfg_idx (0: size, 1: pick count)
//   and must be used only while idle, which the block does not enforce;
//   any write restarts the run and refills the pool.
//   Reset: synchronous, active low; the pool holds identity, size and pick
//   count are 1024 and the draw counter is zero.
// ----------------------------------------------------------------------------
module random_permutation_draw #(
  parameter int MAX_SIZE = rpd_pkg::DEFAULT_MAX_SIZE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rpd_pkg::WORD_W-1:0]      in_random_word,
  output logic                            out_valid,
  output logic [rpd_pkg::PERM_W-1:0]      out_perm_value,
  output logic                            out_last_of_run,
  input  logic                            cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rpd_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_SIZE);
  localparam int CNT_W = IDX_W + 1;

  logic                      div_start;
  logic [rpd_pkg::CFG_W-1:0] div_divisor;
  logic                      div_done;
  logic [rpd_pkg::CFG_W-1:0] div_rem;
  rpd_pkg::pool_cmd_t        pool_cmd;
  logic                      pool_done;
  logic [IDX_W-1:0]          pos;
  logic [CNT_W-1:0]          pool_count;

  // sequencer
  rpd_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .div_start   (div_start),
    .div_divisor (div_divisor),
    .div_done    (div_done),
    .pool_cmd    (pool_cmd),
    .pool_done   (pool_done),
    .out_valid   (out_valid),
    .out_last    (out_last_of_run)
  );

  // remainder unit
  rpd_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_random_word),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  // remainder is below the remaining count, so it fits the pool index
  assign pos        = IDX_W'(div_rem);
  assign pool_count = CNT_W'(div_divisor);

  // value pool
  rpd_pool #(
    .MAX_SIZE (MAX_SIZE)
  ) u_pool (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (pool_cmd),
    .pos     (pos),
    .count   (pool_count),
    .rd_data (out_perm_value),
    .done    (pool_done)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: random permutation draw
// Sends random words through the start/busy port and keeps a software copy of
// the pool, the draw counter and both registers. Each expected draw is queued
// at the accepting edge, and every strobed result word is compared field by
// field against the oldest entry. Covers the register corner cases, restart on
// register write, and a long random stretch of complete and broken runs.
// ----------------------------------------------------------------------------
module testbench;

  localparam int POOL_DEPTH   = rpd_pkg::DEFAULT_MAX_SIZE;
  localparam int RANDOM_WORDS = 2000;
  localparam int STALL_LIMIT  = 8000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [rpd_pkg::PERM_W-1:0] value;
    logic                       last;
  } draw_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [rpd_pkg::WORD_W-1:0]    in_random_word;
  logic                          out_valid;
  logic [rpd_pkg::PERM_W-1:0]    out_perm_value;
  logic                          out_last_of_run;
  logic                          cfg_we;
  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [rpd_pkg::CFG_W-1:0]     cfg_wdata;

  // predicted block state
  logic [rpd_pkg::PERM_W-1:0] pool_model [POOL_DEPTH];
  int unsigned                drawn_count;
  logic [rpd_pkg::CFG_W-1:0]  size_reg;
  logic [rpd_pkg::CFG_W-1:0]  pick_reg;

  draw_t       pending_draws[$];
  int          errors = 0;
  int          mismatches = 0;
  int          random_sent = 0;
  int          quiet_cycles = 0;

  random_permutation_draw dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_random_word (in_random_word),
    .out_valid      (out_valid),
    .out_perm_value (out_perm_value),
    .out_last_of_run(out_last_of_run),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  // pool back to identity, new run
  function automatic void refill_pool();
    for (int i = 0; i < POOL_DEPTH; i++) pool_model[i] = rpd_pkg::PERM_W'(i);
    drawn_count = 0;
  endfunction

  // size after zero and capacity clamping
  function automatic int unsigned active_size();
    if (size_reg == '0) return 1;
    if (size_reg > POOL_DEPTH) return POOL_DEPTH;
    return 32'(size_reg);
  endfunction

  // pick count after zero and size clamping
  function automatic int unsigned active_pick();
    int unsigned s;
    int unsigned p;
    s = active_size();
    p = (pick_reg == '0) ? 1 : 32'(pick_reg);
    return (p > s) ? s : p;
  endfunction

  // one draw without replacement, gap closed by shifting down
  function automatic draw_t draw_from_pool(input logic [rpd_pkg::WORD_W-1:0] word);
    int unsigned remaining;
    int unsigned pos;
    draw_t       d;
    if (drawn_count >= active_pick()) refill_pool();
    remaining = active_size() - drawn_count;
    pos = word % remaining;
    d.value = pool_model[pos];
    for (int unsigned j = pos + 1; j < remaining; j++) pool_model[j-1] = pool_model[j];
    drawn_count++;
    d.last = (drawn_count >= active_pick());
    if (d.last) refill_pool();
    return d;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 8);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [rpd_pkg::WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return $urandom_range(0, 64);
    return $urandom;
  endfunction

  // send one word and queue its draw at the accepting edge
  task automatic send_word(input logic [rpd_pkg::WORD_W-1:0] word);
    int unsigned gap;
    @(negedge clk);
    start <= 1'b1;
    in_random_word <= word;
    do @(posedge clk); while (busy);
    pending_draws.push_back(draw_from_pool(word));
    @(negedge clk);
    start <= 1'b0;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
  endtask

  // register write, only once every draw is back and the block is idle
  task automatic write_reg(input logic [rpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rpd_pkg::CFG_W-1:0] value);
    while (pending_draws.size() != 0 || busy) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == rpd_pkg::REG_PERM_SIZE) size_reg = value;
    else pick_reg = value;
    refill_pool();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // reset registers, word extremes
  task automatic test_defaults();
    send_word('0);
    send_word('1);
    send_word(32'd1023);
    send_word(32'd1024);
    send_word($urandom);
  endtask

  // zero size, oversize, zero pick, pick above size
  task automatic test_register_corners();
    write_reg(rpd_pkg::REG_PERM_SIZE, 11'd0);
    write_reg(rpd_pkg::REG_PICK_COUNT, 11'd2047);
    send_word('0);
    send_word('1);
    write_reg(rpd_pkg::REG_PERM_SIZE, 11'd2047);
    write_reg(rpd_pkg::REG_PICK_COUNT, 11'd0);
    send_word('1);
    send_word(32'h0000_03ff);
    write_reg(rpd_pkg::REG_PERM_SIZE, 11'd2);
    write_reg(rpd_pkg::REG_PICK_COUNT, 11'd2);
    send_word(32'd1);
    send_word(32'd1);
  endtask

  // pick count far above a small size runs the whole pool
  task automatic test_pick_clamp();
    write_reg(rpd_pkg::REG_PERM_SIZE, 11'd4);
    write_reg(rpd_pkg::REG_PICK_COUNT, 11'd1024);
    send_word(32'd3);
    send_word('0);
    send_word('1);
    send_word(32'd7);
  endtask

  // rewriting an unchanged value still restarts the run
  task automatic test_restart_on_write();
    write_reg(rpd_pkg::REG_PERM_SIZE, 11'd6);
    write_reg(rpd_pkg::REG_PICK_COUNT, 11'd6);
    send_word(32'd5);
    send_word('0);
    write_reg(rpd_pkg::REG_PICK_COUNT, 11'd6);
    send_word(32'd5);
    write_reg(rpd_pkg::REG_PERM_SIZE, 11'd6);
    send_word('0);
  endtask

  // new random register setting, mostly small pools
  task automatic pick_config();
    logic [rpd_pkg::CFG_W-1:0] size_val;
    logic [rpd_pkg::CFG_W-1:0] pick_val;
    int unsigned               r;
    int unsigned               which;
    r = $urandom_range(0, 99);
    if (r < 60) size_val = rpd_pkg::CFG_W'($urandom_range(1, 16));
    else if (r < 80) size_val = rpd_pkg::CFG_W'($urandom_range(17, 300));
    else if (r < 88) size_val = 11'd1024;
    else if (r < 94) size_val = rpd_pkg::CFG_W'($urandom_range(1025, 2047));
    else if (r < 97) size_val = 11'd0;
    else size_val = rpd_pkg::CFG_W'($urandom_range(0, 2047));
    r = $urandom_range(0, 99);
    if (r < 50) pick_val = size_val;
    else if (r < 75) pick_val = rpd_pkg::CFG_W'($urandom_range(1, 8));
    else if (r < 90) pick_val = rpd_pkg::CFG_W'($urandom_range(0, 2047));
    else pick_val = 11'd0;
    // keep full runs of large pools rare
    if (pick_val > 64 && size_val > 64 && $urandom_range(0, 9) != 0)
      pick_val = rpd_pkg::CFG_W'($urandom_range(1, 64));
    which = $urandom_range(0, 3);
    if (which != 1) write_reg(rpd_pkg::REG_PERM_SIZE, size_val);
    if (which != 0) write_reg(rpd_pkg::REG_PICK_COUNT, pick_val);
  endtask

  // complete runs with random content, some cut short by a register write
  task automatic test_random_runs();
    int unsigned n;
    while (random_sent < RANDOM_WORDS) begin
      pick_config();
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 5);
      else n = active_pick() * $urandom_range(1, 3) + $urandom_range(0, active_pick() - 1);
      if (n > RANDOM_WORDS - random_sent) n = RANDOM_WORDS - random_sent;
      repeat (n) begin
        send_word(pick_word());
        random_sent++;
      end
    end
  endtask

  // compare each strobed result word with the oldest expected draw
  always @(posedge clk) begin : check_draws
    draw_t want;
    if (rst_n && out_valid) begin
      if (pending_draws.size() == 0) begin
        errors++;
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result word: value %0d last %0b",
                   out_perm_value, out_last_of_run);
        mismatches++;
      end else begin
        want = pending_draws.pop_front();
        if (out_perm_value !== want.value || out_last_of_run !== want.last) begin
          errors++;
          if (mismatches < REPORT_LIMIT)
            $display("draw mismatch: value exp %0d got %0d, last exp %0b got %0b",
                     want.value, out_perm_value, want.last, out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[random_permutation_draw] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_random_word = '0;
    cfg_we = 1'b0;
    cfg_idx = rpd_pkg::REG_PERM_SIZE;
    cfg_wdata = '0;
    size_reg = rpd_pkg::RESET_PERM_SIZE;
    pick_reg = rpd_pkg::RESET_PICK_COUNT;
    refill_pool();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_register_corners();
    test_pick_clamp();
    test_restart_on_write();
    test_random_runs();

    // drain outstanding draws, then let the pipeline settle
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[random_permutation_draw] OK");
    end else begin
      $display("[random_permutation_draw] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rpd_pkg.sv
src/rpd_mod_unit.sv
src/rpd_pool.sv
src/rpd_ctrl.sv
src/random_permutation_draw.sv
dv/testbench.sv
